// ===== design/cba_pkg.sv =====
`default_nettype none

package cba_pkg;

	// Queue geometry: a queue holds QUEUE_DEPTH-1 frames.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	localparam int ID_W = 29;
	localparam int LEN_W = 7;
	localparam int BAUD_W = 24;
	localparam int THRESH_W = 17;
	localparam int DRAW_W = 16;
	localparam int KIND_W = 3;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(64);
	localparam logic [LEN_W-1:0] IFS_BITS = LEN_W'(44);

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CONFIRM = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELIVER = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BUS_ERR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ARB_LOST = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INTERVAL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_IDLE = 3'd5;

	// Result selection from controller to datapath
	localparam logic [1:0] EM_NOTE = 2'd0;
	localparam logic [1:0] EM_LOST = 2'd1;
	localparam logic [1:0] EM_INTERVAL = 2'd2;
	localparam logic [1:0] EM_IDLE = 2'd3;

	// Register map, byte address 4*index
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_BAUD0 = 3'd0;
	localparam logic [2:0] REG_BAUD1 = 3'd1;
	localparam logic [2:0] REG_DISCARD0 = 3'd2;
	localparam logic [2:0] REG_DISCARD1 = 3'd3;
	localparam logic [2:0] REG_THRESH = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic ext;
		logic rtr;
		logic [LEN_W-1:0] len;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	typedef struct packed {
		logic [BAUD_W-1:0] baud0;
		logic [BAUD_W-1:0] baud1;
		logic [1:0] discard;
		logic [THRESH_W-1:0] threshold;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic write_frame;
		logic start_tick;
		logic pop;
		logic emit;
		logic [1:0] emit_sel;
		logic last;
		logic node;
	} cmd_t;

	typedef struct packed {
		logic [1:0] empty;
		logic [1:0] empty_after_pop;
		logic out_free;
	} sts_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/cba_ram.sv =====
`default_nettype none

module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/cba_regs.sv =====
`default_nettype none

module cba_regs import cba_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_BAUD0:    cfg_q.baud0 <= pwdata[BAUD_W-1:0];
				REG_BAUD1:    cfg_q.baud1 <= pwdata[BAUD_W-1:0];
				REG_DISCARD0: cfg_q.discard[0] <= pwdata[0];
				REG_DISCARD1: cfg_q.discard[1] <= pwdata[0];
				REG_THRESH:   cfg_q.threshold <= pwdata[THRESH_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BAUD0:    prdata = 32'(cfg_q.baud0);
			REG_BAUD1:    prdata = 32'(cfg_q.baud1);
			REG_DISCARD0: prdata = 32'(cfg_q.discard[0]);
			REG_DISCARD1: prdata = 32'(cfg_q.discard[1]);
			REG_THRESH:   prdata = 32'(cfg_q.threshold);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/cba_ctrl.sv =====
`default_nettype none

module cba_ctrl import cba_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       operation,
	input  wire logic [1:0] discard,
	input  wire sts_t       sts,
	output logic            in_stall,
	output cmd_t            cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_TICK  = 3'd2;
	localparam logic [2:0] S_NOTE  = 3'd3;
	localparam logic [2:0] S_DISC  = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;

	logic [2:0] state_q, state_d;
	logic node_q, node_d;
	logic pending_q, pending_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_q <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			node_q <= node_d;
			pending_q <= pending_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.node = node_q;
		state_d = state_q;
		node_d = node_q;
		pending_d = pending_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (operation) begin
						state_d = S_TICK;
					end else begin
						// frame goes into its queue at the accept edge
						cmd.write_frame = 1'b1;
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				// queue RAM read refreshes after the write
				state_d = S_CHECK;
			end
			S_TICK: begin
				pending_d = 1'b0;
				if (&sts.empty) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_sel = EM_IDLE;
						cmd.last = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.start_tick = 1'b1;
					node_d = 1'b0;
					state_d = S_NOTE;
				end
			end
			S_NOTE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EM_NOTE;
					cmd.last = node_q & (&sts.empty);
					if (discard[node_q] && !sts.empty[node_q]) begin
						state_d = S_DISC;
					end else if (!node_q) begin
						node_d = 1'b1;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_DISC: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EM_LOST;
					cmd.pop = 1'b1;
					cmd.last = node_q & sts.empty_after_pop[1] & sts.empty[0];
					if (sts.empty_after_pop[node_q]) begin
						if (!node_q) begin
							node_d = 1'b1;
							state_d = S_NOTE;
						end else begin
							state_d = S_CHECK;
						end
					end
				end
			end
			S_CHECK: begin
				if (pending_q || (&sts.empty)) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EM_INTERVAL;
					cmd.last = 1'b1;
					pending_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/cba_dp.sv =====
`default_nettype none

module cba_dp import cba_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire cfg_t                  cfg,
	input  wire logic                  source_node,
	input  wire logic [ID_W-1:0]       frame_id,
	input  wire logic                  extended_id,
	input  wire logic                  remote_request,
	input  wire logic [LEN_W-1:0]      data_length,
	input  wire logic [DRAW_W-1:0]     random_draw,
	input  wire logic                  out_stall,
	output sts_t                       sts,
	output logic                       out_valid,
	output logic      [KIND_W-1:0]     kind,
	output logic                       dest_node,
	output logic      [ID_W-1:0]       out_frame_id,
	output logic                       out_extended_id,
	output logic                       out_remote_request,
	output logic      [LEN_W-1:0]      out_data_length,
	output logic                       error_at_originator,
	output logic      [LEN_W-1:0]      interval_count,
	output logic      [BAUD_W-1:0]     interval_resolution,
	output logic                       last
);

	logic [1:0][PTR_W-1:0] wptr_q, rptr_q, raddr;
	logic [1:0][FRAME_W-1:0] rdata;
	logic [1:0] empty, full, empty_ap, we, pop_g;
	frame_t head [2];
	frame_t in_frame;
	logic who_c;

	logic [DRAW_W-1:0] draw_q;
	frame_t win_q;
	logic who_q, err_q;

	logic out_valid_q;
	logic [KIND_W-1:0] kind_d, kind_q;
	logic dest_d, dest_q;
	logic [ID_W-1:0] id_d, id_q;
	logic ext_d, ext_q, rtr_d, rtr_q, orig_d, orig_q;
	logic [LEN_W-1:0] len_d, len_q, cnt_d, cnt_q;
	logic [BAUD_W-1:0] res_d, res_q, agreed;
	logic last_q;
	logic out_free;

	assign in_frame.id = frame_id;
	assign in_frame.ext = extended_id;
	assign in_frame.rtr = remote_request;
	assign in_frame.len = (data_length > MAX_LEN) ? MAX_LEN : data_length;

	// lowest identifier wins, node 0 on ties
	assign who_c = empty[0] | (!empty[1] & (head[1].id < head[0].id));

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			head[g] = frame_t'(rdata[g]);
			empty[g] = (rptr_q[g] == wptr_q[g]);
			full[g] = (ptr_next(wptr_q[g]) == rptr_q[g]);
			empty_ap[g] = (ptr_next(rptr_q[g]) == wptr_q[g]);
			we[g] = cmd.write_frame & (source_node == 1'(g)) & !full[g];
			pop_g[g] = (cmd.start_tick & (who_c == 1'(g))) | (cmd.pop & (cmd.node == 1'(g)));
			// read ahead on pop so the head stays current
			raddr[g] = pop_g[g] ? ptr_next(rptr_q[g]) : rptr_q[g];
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_queue
		cba_ram #(
			.WIDTH(FRAME_W),
			.DEPTH(QUEUE_DEPTH)
		) u_ram (
			.clk(clk),
			.we(we[g]),
			.waddr(wptr_q[g]),
			.wdata(in_frame),
			.raddr(raddr[g]),
			.rdata(rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			for (int g = 0; g < 2; g++) begin
				if (we[g]) begin
					wptr_q[g] <= ptr_next(wptr_q[g]);
				end
				if (pop_g[g]) begin
					rptr_q[g] <= raddr[g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			draw_q <= random_draw;
		end
		if (cmd.start_tick) begin
			win_q <= head[who_c];
			who_q <= who_c;
			err_q <= ({1'b0, draw_q} < cfg.threshold);
		end
	end

	assign agreed = (cfg.baud0 != '0 && cfg.baud0 == cfg.baud1) ? cfg.baud0 : '0;

	always_comb begin
		kind_d = KIND_IDLE;
		dest_d = 1'b0;
		id_d = '0;
		ext_d = 1'b0;
		rtr_d = 1'b0;
		len_d = '0;
		orig_d = 1'b0;
		cnt_d = '0;
		res_d = '0;
		unique case (cmd.emit_sel)
			EM_NOTE: begin
				dest_d = cmd.node;
				id_d = win_q.id;
				if (err_q) begin
					kind_d = KIND_BUS_ERR;
					orig_d = (cmd.node == who_q);
				end else if (cmd.node == who_q) begin
					kind_d = KIND_CONFIRM;
				end else begin
					kind_d = KIND_DELIVER;
					ext_d = win_q.ext;
					rtr_d = win_q.rtr;
					len_d = win_q.len;
				end
			end
			EM_LOST: begin
				kind_d = KIND_ARB_LOST;
				dest_d = cmd.node;
				id_d = head[cmd.node].id;
			end
			EM_INTERVAL: begin
				kind_d = KIND_INTERVAL;
				cnt_d = IFS_BITS + head[who_c].len;
				res_d = agreed;
			end
			EM_IDLE: begin
				kind_d = KIND_IDLE;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= kind_d;
			dest_q <= dest_d;
			id_q <= id_d;
			ext_q <= ext_d;
			rtr_q <= rtr_d;
			len_q <= len_d;
			orig_q <= orig_d;
			cnt_q <= cnt_d;
			res_q <= res_d;
			last_q <= cmd.last;
		end
	end

	assign sts.empty = empty;
	assign sts.empty_after_pop = empty_ap;
	assign sts.out_free = out_free;

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign dest_node = dest_q;
	assign out_frame_id = id_q;
	assign out_extended_id = ext_q;
	assign out_remote_request = rtr_q;
	assign out_data_length = len_q;
	assign error_at_originator = orig_q;
	assign interval_count = cnt_q;
	assign interval_resolution = res_q;
	assign last = last_q;

endmodule

`default_nettype wire

// ===== design/two_node_can_bus_arbiter_core.sv =====
`default_nettype none

// Two-node CAN bus arbiter. Each node owns a 15-frame queue (a 16-entry RAM with
// registered read); an offer to a full queue is dropped silently. A transmit tick
// pops the lowest-identifier head (node 0 wins ties), sends a confirm/delivery or a
// bus error to each node, and in discard mode flushes that node's queue with one
// arbitration-lost result per frame. After every transaction a next-interval result
// (44 + winner length, agreed baud) follows when none is pending and a frame waits;
// the last result of a transaction has last set. An offer writes the frame, lets
// the RAM read refresh, then does the interval check. A tick with both queues
// empty only emits an idle result; any other tick pops the winner, emits each
// confirm, delivery, bus error or arbitration-lost result in turn, and sends the
// next-interval result, when there is one, in the final check state. Each result
// waits while the output register is held by out_stall. Items are accepted one
// at a time; the user must write registers only while idle (not enforced here).
module two_node_can_bus_arbiter_core import cba_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  operation,
	input  wire logic                  source_node,
	input  wire logic [ID_W-1:0]       frame_id,
	input  wire logic                  extended_id,
	input  wire logic                  remote_request,
	input  wire logic [LEN_W-1:0]      data_length,
	input  wire logic [DRAW_W-1:0]     random_draw,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [KIND_W-1:0]     kind,
	output logic                       dest_node,
	output logic      [ID_W-1:0]       out_frame_id,
	output logic                       out_extended_id,
	output logic                       out_remote_request,
	output logic      [LEN_W-1:0]      out_data_length,
	output logic                       error_at_originator,
	output logic      [LEN_W-1:0]      interval_count,
	output logic      [BAUD_W-1:0]     interval_resolution,
	output logic                       last
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	cba_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	cba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.operation(operation),
		.discard(cfg.discard),
		.sts(sts),
		.in_stall(in_stall),
		.cmd(cmd)
	);

	cba_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.source_node(source_node),
		.frame_id(frame_id),
		.extended_id(extended_id),
		.remote_request(remote_request),
		.data_length(data_length),
		.random_draw(random_draw),
		.out_stall(out_stall),
		.sts(sts),
		.out_valid(out_valid),
		.kind(kind),
		.dest_node(dest_node),
		.out_frame_id(out_frame_id),
		.out_extended_id(out_extended_id),
		.out_remote_request(out_remote_request),
		.out_data_length(out_data_length),
		.error_at_originator(error_at_originator),
		.interval_count(interval_count),
		.interval_resolution(interval_resolution),
		.last(last)
	);

endmodule

`default_nettype wire
